// File: design/pbp_pkg.sv
// ----------------------------------------------------------------------------
// Perceptron predictor package
// Sizes, opcodes and the command/status bundles shared by the predictor files.
// ----------------------------------------------------------------------------
package pbp_pkg;

  localparam int ROW_COUNT      = 256;
  localparam int HISTORY_LENGTH = 16;
  localparam int WEIGHT_BITS    = 8;

  localparam int ADDR_BITS    = 32;
  localparam int THRESH_BITS  = 12;
  localparam int THRESH_RESET = 45;
  localparam int OUT_SUM_BITS = 13;

  localparam int ROW_BITS    = $clog2(ROW_COUNT);
  localparam bit ROW_POW2    = ((ROW_COUNT & (ROW_COUNT - 1)) == 0);
  localparam int NUM_WEIGHTS = HISTORY_LENGTH + 1;
  localparam int ROW_WIDTH   = NUM_WEIGHTS * WEIGHT_BITS;

  // largest possible |sum|: every weight at its largest magnitude
  localparam int MAX_MAG  = NUM_WEIGHTS * (2 ** (WEIGHT_BITS - 1) - 1);
  localparam int SUM_BITS = $clog2(MAX_MAG + 1) + 1;
  localparam int ACC_BITS = (SUM_BITS > OUT_SUM_BITS) ? SUM_BITS : OUT_SUM_BITS;

  localparam int GROUP_SIZE = 8;
  localparam int NUM_GROUPS = (NUM_WEIGHTS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int CNT_BITS   = $clog2(ADDR_BITS + 1);

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  typedef struct packed {
    logic start;         // latch the accepted transaction
    logic mem_read;      // read the selected weight row
    logic update_row;    // train the row (if needed) and shift history
    logic load_partial;  // register the group partial sums
    logic load_result;   // finish the sum and load the output register
  } pbp_cmd_t;

  typedef struct packed {
    logic is_update;
    logic row_done;
    logic out_free;
  } pbp_status_t;

endpackage

// File: design/pbp_channels.sv
// ----------------------------------------------------------------------------
// Perceptron predictor channels
// Valid/ready interfaces for the branch, result and configuration channels.
// ----------------------------------------------------------------------------
interface pbp_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] branch_address;
  logic        resolved_taken;

  modport source (output valid, output operation, output branch_address,
                  output resolved_taken, input ready);
  modport sink   (input valid, input operation, input branch_address,
                  input resolved_taken, output ready);
endinterface

interface pbp_out_if;
  logic               valid;
  logic               ready;
  logic               predict_taken;
  logic signed [12:0] perceptron_sum;

  modport source (output valid, output predict_taken, output perceptron_sum,
                  input ready);
  modport sink   (input valid, input predict_taken, input perceptron_sum,
                  output ready);
endinterface

interface pbp_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/pbp_ctrl.sv
// ----------------------------------------------------------------------------
// Perceptron predictor controller
// Sequences one transaction at a time through index, read, sum and write.
// ----------------------------------------------------------------------------
module pbp_ctrl import pbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output pbp_cmd_t    cmd,
  input  pbp_status_t status
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_INDEX = 2'd1;
  localparam logic [1:0] S_CALC  = 2'd2;
  localparam logic [1:0] S_SUM   = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          if (ROW_POW2) begin
            cmd.mem_read = 1'b1;
            state_nxt    = S_CALC;
          end else begin
            state_nxt = S_INDEX;
          end
        end
      end
      S_INDEX: begin
        if (status.row_done) begin
          cmd.mem_read = 1'b1;
          state_nxt    = S_CALC;
        end
      end
      S_CALC: begin
        if (status.is_update) begin
          cmd.update_row = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          cmd.load_partial = 1'b1;
          state_nxt        = S_SUM;
        end
      end
      S_SUM: begin
        // hold until the output register can take the result
        if (status.out_free) begin
          cmd.load_result = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CALC || state_r == S_INDEX))
    else $error("accepted transaction did not start processing");

  a_predict_goes_to_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CALC && !status.is_update) |=> (state_r == S_SUM))
    else $error("predict skipped the final sum");
`endif

endmodule

// File: design/pbp_datapath.sv
// ----------------------------------------------------------------------------
// Perceptron predictor datapath
// Weight memory, history, summing tree, training logic and output register.
// ----------------------------------------------------------------------------
module pbp_datapath import pbp_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pbp_cmd_t                       cmd,
  output pbp_status_t                    status,
  input  logic                           in_operation,
  input  logic [ADDR_BITS-1:0]           in_branch_address,
  input  logic                           in_resolved_taken,
  input  logic                           cfg_valid,
  input  logic [THRESH_BITS-1:0]         cfg_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           out_predict_taken,
  output logic signed [OUT_SUM_BITS-1:0] out_perceptron_sum
);

  localparam logic signed [WEIGHT_BITS:0] W_LIMIT     = (WEIGHT_BITS + 1)'(2 ** (WEIGHT_BITS - 1));
  localparam logic signed [WEIGHT_BITS:0] W_NEG_LIMIT = -W_LIMIT;

  // transaction and configuration registers
  logic                   op_r;
  logic                   taken_r;
  logic [ROW_BITS-1:0]    row_r;
  logic [THRESH_BITS-1:0] thresh_r;

  // weight memory with per-row valid bits (an invalid row reads as zero)
  logic [ROW_WIDTH-1:0] mem [ROW_COUNT];
  logic [ROW_COUNT-1:0] row_valid_r;
  logic [ROW_WIDTH-1:0] rdata_r;
  logic                 rvalid_r;
  logic [ROW_WIDTH-1:0] row_w;
  logic [ROW_WIDTH-1:0] wdata;
  logic [ROW_BITS-1:0]  rd_addr;
  logic                 row_done;

  logic [HISTORY_LENGTH-1:0] hist_valid_r, hist_valid_nxt;
  logic [HISTORY_LENGTH-1:0] hist_taken_r, hist_taken_nxt;

  logic signed [WEIGHT_BITS-1:0] wt    [NUM_WEIGHTS];
  logic signed [ACC_BITS-1:0]    term  [NUM_WEIGHTS];
  logic signed [1:0]             delta [NUM_WEIGHTS];
  logic signed [WEIGHT_BITS:0]   wsum  [NUM_WEIGHTS];

  logic signed [ACC_BITS-1:0] part_r   [NUM_GROUPS];
  logic signed [ACC_BITS-1:0] part_nxt [NUM_GROUPS];
  logic signed [ACC_BITS-1:0] total;
  logic signed [ACC_BITS-1:0] last_sum_r;

  logic                last_neg;
  logic [ACC_BITS-1:0] last_mag;
  logic                train;

  logic                          out_valid_r;
  logic                          out_taken_r;
  logic signed [OUT_SUM_BITS-1:0] out_sum_r;

  // ---------------- row index ----------------
  generate
    if (ROW_POW2) begin : g_idx_mask
      assign rd_addr  = in_branch_address[ROW_BITS-1:0];
      assign row_done = 1'b1;
    end else begin : g_idx_serial
      // restoring remainder, one address bit a cycle
      localparam logic [ROW_BITS:0] ROW_COUNT_W = (ROW_BITS + 1)'(ROW_COUNT);
      logic [ADDR_BITS-1:0] pcs_r;
      logic [ROW_BITS-1:0]  rem_r;
      logic [CNT_BITS-1:0]  cnt_r;
      logic [ROW_BITS:0]    trial;

      assign trial    = {rem_r, pcs_r[ADDR_BITS-1]};
      assign rd_addr  = rem_r;
      assign row_done = (cnt_r == '0);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          cnt_r <= '0;
        end else if (cmd.start) begin
          cnt_r <= CNT_BITS'(ADDR_BITS);
        end else if (cnt_r != '0) begin
          cnt_r <= cnt_r - 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (cmd.start) begin
          pcs_r <= in_branch_address;
          rem_r <= '0;
        end else if (cnt_r != '0) begin
          pcs_r <= {pcs_r[ADDR_BITS-2:0], 1'b0};
          if (trial >= ROW_COUNT_W) begin
            rem_r <= ROW_BITS'(trial - ROW_COUNT_W);
          end else begin
            rem_r <= trial[ROW_BITS-1:0];
          end
        end
      end
    end
  endgenerate

  // ---------------- transaction and config ----------------
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r    <= in_operation;
      taken_r <= in_resolved_taken;
    end
    if (cmd.mem_read) begin
      row_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_BITS'(THRESH_RESET);
    end else if (cfg_valid) begin
      thresh_r <= cfg_data;
    end
  end

  // ---------------- weight memory ----------------
  always_ff @(posedge clk) begin
    if (cmd.update_row && train) begin
      mem[row_r] <= wdata;
    end
    if (cmd.mem_read) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rvalid_r    <= 1'b0;
    end else begin
      if (cmd.update_row && train) begin
        row_valid_r[row_r] <= 1'b1;
      end
      if (cmd.mem_read) begin
        rvalid_r <= row_valid_r[rd_addr];
      end
    end
  end

  assign row_w = rvalid_r ? rdata_r : '0;

  // ---------------- per-weight terms and training ----------------
  genvar k;
  generate
    for (k = 0; k < NUM_WEIGHTS; k++) begin : g_w
      assign wt[k] = row_w[k*WEIGHT_BITS +: WEIGHT_BITS];
      if (k == 0) begin : g_bias
        assign term[k]  = ACC_BITS'(wt[k]);
        assign delta[k] = taken_r ? 2'sb01 : 2'sb11;
      end else begin : g_hist
        assign term[k]  = !hist_valid_r[k-1] ? '0 :
                          (hist_taken_r[k-1] ? ACC_BITS'(wt[k]) : -ACC_BITS'(wt[k]));
        assign delta[k] = !hist_valid_r[k-1] ? 2'sb00 :
                          ((hist_taken_r[k-1] == taken_r) ? 2'sb01 : 2'sb11);
      end
      assign wsum[k] = (WEIGHT_BITS + 1)'(wt[k]) + (WEIGHT_BITS + 1)'(delta[k]);
      // a magnitude that reaches the limit wraps to zero
      assign wdata[k*WEIGHT_BITS +: WEIGHT_BITS] =
        (wsum[k] == W_LIMIT || wsum[k] == W_NEG_LIMIT) ? '0 : wsum[k][WEIGHT_BITS-1:0];
    end
  endgenerate

  assign last_neg = last_sum_r[ACC_BITS-1];
  assign last_mag = last_neg ? ACC_BITS'(-last_sum_r) : ACC_BITS'(last_sum_r);
  assign train    = (last_neg ? taken_r : !taken_r) ||
                    (last_mag <= ACC_BITS'(thresh_r));

  // ---------------- history ----------------
  always_comb begin
    for (int i = 0; i < HISTORY_LENGTH - 1; i++) begin
      hist_valid_nxt[i] = hist_valid_r[i+1];
      hist_taken_nxt[i] = hist_taken_r[i+1];
    end
    hist_valid_nxt[HISTORY_LENGTH-1] = 1'b1;
    hist_taken_nxt[HISTORY_LENGTH-1] = taken_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_valid_r <= '0;
      hist_taken_r <= '0;
    end else if (cmd.update_row) begin
      hist_valid_r <= hist_valid_nxt;
      hist_taken_r <= hist_taken_nxt;
    end
  end

  // ---------------- summing tree ----------------
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      part_nxt[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < NUM_WEIGHTS) begin
          part_nxt[g] = part_nxt[g] + term[g*GROUP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_partial) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        part_r[g] <= part_nxt[g];
      end
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      total = total + part_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sum_r <= '0;
    end else if (cmd.load_result) begin
      last_sum_r <= total;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_taken_r <= !total[ACC_BITS-1];
      out_sum_r   <= total[OUT_SUM_BITS-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_predict_taken  = out_taken_r;
  assign out_perceptron_sum = out_sum_r;

  assign status.is_update = (op_r == OP_UPDATE);
  assign status.row_done  = row_done;
  assign status.out_free  = !out_valid_r || out_ready;

`ifndef SYNTHESIS
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.load_result))
    else $error("result appeared without a completed sum");

  a_write_only_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update_row |-> (op_r == OP_UPDATE))
    else $error("row write on a predict transaction");

  a_trained_row_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update_row && train) |=> row_valid_r[$past(row_r)])
    else $error("trained row not marked valid");
`endif

endmodule

// File: design/perceptron_branch_predictor.sv
// ----------------------------------------------------------------------------
// Perceptron branch predictor
// Usage:
//   in_ch   : one transaction per branch. operation 0 predicts for
//             branch_address, operation 1 trains with resolved_taken against
//             the sum kept from the latest predict, then shifts the history.
//   out_ch  : one result (predict_taken, perceptron_sum) per predict only.
//   cfg_ch  : writes train_threshold; always ready, write only while idle.
// Timing: one transaction at a time. A predict reads the row (at the accept
//   edge when the row count is a power of two), registers the group partial
//   sums, then does the final add into the output register; an update reads
//   the row, then trains and writes it back. The registered weight memory
//   read and the two-step sum set these steps. With a row count that is not
//   a power of two, a serial remainder unit first computes the row index.
// Reset: synchronous rst_n clears the history, the kept sum, the output and
//   the per-row valid bits, so every weight reads as zero; the threshold
//   returns to 45. No clearing pass is needed.
// Stall: a finished result waits in the output register; the next
//   transaction is still accepted, and a later predict holds in its final
//   sum step until the output register frees up.
// ----------------------------------------------------------------------------
module perceptron_branch_predictor import pbp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  pbp_in_if.sink     in_ch,
  pbp_out_if.source  out_ch,
  pbp_cfg_if.sink    cfg_ch
);

  pbp_cmd_t    cmd;
  pbp_status_t status;
  logic        in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  pbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  pbp_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_operation       (in_ch.operation),
    .in_branch_address  (in_ch.branch_address),
    .in_resolved_taken  (in_ch.resolved_taken),
    .cfg_valid          (cfg_ch.valid),
    .cfg_data           (cfg_ch.data),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_predict_taken  (out_ch.predict_taken),
    .out_perceptron_sum (out_ch.perceptron_sum)
  );

endmodule
